>>> rtl/ptro_pkg.sv
`timescale 1ns / 1ps
// Package for the twin rail offset block: fixed widths of the offset datapath,
// reset value of the half gauge register and the controller state type.
// No dependencies.
package ptro_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int GAUGE_BITS     = 18;
    localparam int NORM_BITS      = 24;
    localparam int SQ_SHIFT       = 14;
    localparam int NUM_SHIFT      = 8;
    localparam int PROD_W         = 2 * NORM_BITS;
    localparam int SQ_PAIRS       = (PROD_W + 1 + SQ_SHIFT + 1) / 2;
    localparam int RAD_W          = 2 * SQ_PAIRS;
    localparam int ROOT_W         = SQ_PAIRS;
    localparam int REM_W          = ROOT_W + 3;
    localparam int D_W            = ROOT_W + 1;
    localparam int NUM_W          = PROD_W + NUM_SHIFT + 1;
    localparam int Q_W            = GAUGE_BITS;
    localparam int CNT_W          = $clog2(ROOT_W + 1);
    localparam int MUL_STEPS      = 4;

    localparam logic [GAUGE_BITS-1:0] HALF_GAUGE_RST = GAUGE_BITS'(47022);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_NORM,
        S_MUL,
        S_SQRT,
        S_DIVLD,
        S_DIV,
        S_ADD
    } t_state;

endpackage

>>> rtl/polyline_twin_rail_offset.sv
`timescale 1ns / 1ps
// Top level of the twin rail offset block: vertex history, bit-serial
// normalize, square root and divide, saturating rail point output.
// Depends on ptro_pkg.
//
// Steps from input beat to result: load, normalize, products, square root one
// bit per cycle, divide setup, two divides one quotient bit per cycle in
// parallel, output load (a zero-length tangent skips from load to output load);
// a stalled result register holds the job. Throughput: one job at a time; input
// ready again the cycle after the result loads unless an end job is pending;
// a final vertex after a held one runs a second job. Reset: synchronous, clears
// vertex count, controller and output valid; half gauge returns to 47022.
module polyline_twin_rail_offset
    import ptro_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [GAUGE_BITS-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    input  logic                  i_final_vertex,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_left_x,
    output logic [COORD_BITS-1:0] o_left_y,
    output logic [COORD_BITS-1:0] o_right_x,
    output logic [COORD_BITS-1:0] o_right_y,
    output logic                  o_end_of_line
);

    localparam int C     = COORD_BITS;
    localparam int MAG_W = ((C > NORM_BITS) ? C : NORM_BITS) + 1;
    localparam int SUM_W = ((C > GAUGE_BITS + 1) ? C : GAUGE_BITS + 1) + 1;

    t_state r_state, n_state;

    logic [GAUGE_BITS-1:0] r_gauge;
    logic [1:0]            r_seen;
    logic [C-1:0]          r_old_x, r_old_y, r_new_x, r_new_y;

    logic [C-1:0] r_px, r_py, r_j2_px, r_j2_py;
    logic [C:0]   r_dx, r_dy, r_j2_dx, r_j2_dy;
    logic         r_end, r_j2_v;

    logic [MAG_W-1:0]  r_a, r_b;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_prod, r_asq, r_nx, r_ny;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [D_W-1:0]    r_den, r_drx, r_dry;
    logic [Q_W-1:0]    r_nlx, r_nly, r_qx, r_qy;
    logic              r_ov;

    logic         accept, in_job, fin;
    logic [C:0]   in_dx, in_dy, j2_dx, j2_dy;
    logic [C-1:0] base_x, base_y;

    assign o_ready = (r_state == S_IDLE) && !r_j2_v;
    assign accept  = i_valid && o_ready;
    assign fin     = i_final_vertex;
    assign in_job  = !((r_seen == 2'd0) && !fin);
    assign base_x  = (r_seen == 2'd1) ? r_new_x : r_old_x;
    assign base_y  = (r_seen == 2'd1) ? r_new_y : r_old_y;
    assign in_dx   = {i_x_coord[C-1], i_x_coord} - {base_x[C-1], base_x};
    assign in_dy   = {i_y_coord[C-1], i_y_coord} - {base_y[C-1], base_y};
    assign j2_dx   = {i_x_coord[C-1], i_x_coord} - {r_new_x[C-1], r_new_x};
    assign j2_dy   = {i_y_coord[C-1], i_y_coord} - {r_new_y[C-1], r_new_y};

    logic [C:0]       mag_dx, mag_dy;
    logic [MAG_W-1:0] ab_or;
    logic             norm_hi, norm_ok;
    assign mag_dx  = r_dx[C] ? -r_dx : r_dx;
    assign mag_dy  = r_dy[C] ? -r_dy : r_dy;
    assign ab_or   = r_a | r_b;
    assign norm_hi = |ab_or[MAG_W-1:NORM_BITS];
    assign norm_ok = !norm_hi && ab_or[NORM_BITS-1];

    logic [NORM_BITS-1:0] mop1, mop2;
    always_comb begin
        case (r_cnt)
            CNT_W'(0): begin mop1 = r_a[NORM_BITS-1:0]; mop2 = r_a[NORM_BITS-1:0]; end
            CNT_W'(1): begin mop1 = r_b[NORM_BITS-1:0]; mop2 = r_b[NORM_BITS-1:0]; end
            CNT_W'(2): begin mop1 = NORM_BITS'(r_gauge); mop2 = r_a[NORM_BITS-1:0]; end
            CNT_W'(3): begin mop1 = NORM_BITS'(r_gauge); mop2 = r_b[NORM_BITS-1:0]; end
            default:   begin mop1 = '0; mop2 = '0; end
        endcase
    end

    logic [REM_W-1:0] rem_sh, trial;
    logic             sq_take;
    assign rem_sh  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign sq_take = rem_sh >= trial;

    logic [NUM_W-1:0] num_x, num_y;
    assign num_x = {1'b0, r_nx, NUM_SHIFT'(0)} + NUM_W'(r_root);
    assign num_y = {1'b0, r_ny, NUM_SHIFT'(0)} + NUM_W'(r_root);

    logic [D_W:0] tx, ty, dext;
    logic         qxb, qyb;
    assign tx   = {r_drx, r_nlx[Q_W-1]};
    assign ty   = {r_dry, r_nly[Q_W-1]};
    assign dext = {1'b0, r_den};
    assign qxb  = tx >= dext;
    assign qyb  = ty >= dext;

    function automatic logic [C-1:0] sat(input logic [SUM_W-1:0] s);
        logic ovf;
        ovf = (s[SUM_W-1:C-1] != {(SUM_W-C+1){1'b0}})
           && (s[SUM_W-1:C-1] != {(SUM_W-C+1){1'b1}});
        if (!ovf)
            return s[C-1:0];
        else if (s[SUM_W-1])
            return {1'b1, {(C-1){1'b0}}};
        else
            return {1'b0, {(C-1){1'b1}}};
    endfunction

    logic [SUM_W-1:0] px_e, py_e, offx, offy;
    logic             out_load;
    assign px_e     = SUM_W'($signed(r_px));
    assign py_e     = SUM_W'($signed(r_py));
    assign offx     = r_dy[C] ? SUM_W'(r_qy) : -SUM_W'(r_qy);
    assign offy     = r_dx[C] ? -SUM_W'(r_qx) : SUM_W'(r_qx);
    assign out_load = (r_state == S_ADD) && (!r_ov || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_j2_v || (accept && in_job))
                    n_state = S_LOAD;
            end
            S_LOAD: begin
                if ((mag_dx == '0) && (mag_dy == '0))
                    n_state = S_ADD;
                else
                    n_state = S_NORM;
            end
            S_NORM: begin
                if (norm_ok)
                    n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS))
                    n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_cnt == CNT_W'(ROOT_W - 1))
                    n_state = S_DIVLD;
            end
            S_DIVLD: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(Q_W - 1))
                    n_state = S_ADD;
            end
            S_ADD: begin
                if (out_load)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gauge <= HALF_GAUGE_RST;
            r_seen  <= 2'd0;
            r_j2_v  <= 1'b0;
            r_old_x <= '0;
            r_old_y <= '0;
            r_new_x <= '0;
            r_new_y <= '0;
        end else begin
            if (i_cfg_we)
                r_gauge <= i_cfg_data;
            if (r_state == S_IDLE && r_j2_v)
                r_j2_v <= 1'b0;
            if (accept) begin
                if (fin) begin
                    r_seen <= 2'd0;
                    r_j2_v <= (r_seen != 2'd0);
                end else begin
                    r_seen  <= (r_seen == 2'd0) ? 2'd1 : 2'd2;
                    r_old_x <= r_new_x;
                    r_old_y <= r_new_y;
                    r_new_x <= i_x_coord;
                    r_new_y <= i_y_coord;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_j2_px <= i_x_coord;
            r_j2_py <= i_y_coord;
            r_j2_dx <= j2_dx;
            r_j2_dy <= j2_dy;
        end
        r_cnt <= '0;
        unique case (r_state)
            S_IDLE: begin
                if (r_j2_v) begin
                    r_px  <= r_j2_px;
                    r_py  <= r_j2_py;
                    r_dx  <= r_j2_dx;
                    r_dy  <= r_j2_dy;
                    r_end <= 1'b1;
                end else if (r_seen == 2'd0) begin
                    r_px  <= i_x_coord;
                    r_py  <= i_y_coord;
                    r_dx  <= (C+1)'(1);
                    r_dy  <= '0;
                    r_end <= 1'b1;
                end else begin
                    r_px  <= r_new_x;
                    r_py  <= r_new_y;
                    r_dx  <= in_dx;
                    r_dy  <= in_dy;
                    r_end <= 1'b0;
                end
            end
            S_LOAD: begin
                r_a  <= MAG_W'(mag_dx[C-1:0]);
                r_b  <= MAG_W'(mag_dy[C-1:0]);
                r_qx <= '0;
                r_qy <= '0;
            end
            S_NORM: begin
                if (norm_hi) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                end else if (!ab_or[NORM_BITS-1]) begin
                    r_a <= r_a << 1;
                    r_b <= r_b << 1;
                end
            end
            S_MUL: begin
                r_cnt  <= r_cnt + CNT_W'(1);
                r_prod <= PROD_W'(mop1 * mop2);
                if (r_cnt == CNT_W'(1))
                    r_asq <= r_prod;
                if (r_cnt == CNT_W'(2))
                    r_rad <= RAD_W'({1'b0, r_asq} + {1'b0, r_prod}) << SQ_SHIFT;
                if (r_cnt == CNT_W'(3))
                    r_nx <= r_prod;
                if (r_cnt == CNT_W'(MUL_STEPS)) begin
                    r_ny   <= r_prod;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end
            end
            S_SQRT: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_rad <= r_rad << 2;
                if (sq_take) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            S_DIVLD: begin
                r_den <= {r_root, 1'b0};
                r_drx <= num_x[Q_W +: D_W];
                r_dry <= num_y[Q_W +: D_W];
                r_nlx <= num_x[Q_W-1:0];
                r_nly <= num_y[Q_W-1:0];
            end
            S_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_nlx <= r_nlx << 1;
                r_nly <= r_nly << 1;
                r_qx  <= {r_qx[Q_W-2:0], qxb};
                r_qy  <= {r_qy[Q_W-2:0], qyb};
                r_drx <= qxb ? D_W'(tx - dext) : tx[D_W-1:0];
                r_dry <= qyb ? D_W'(ty - dext) : ty[D_W-1:0];
            end
            S_ADD: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (out_load)
            r_ov <= 1'b1;
        else if (i_ready)
            r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_left_x      <= sat(px_e + offx);
            o_left_y      <= sat(py_e + offy);
            o_right_x     <= sat(px_e - offx);
            o_right_y     <= sat(py_e - offy);
            o_end_of_line <= r_end;
        end
    end

    assign o_valid = r_ov;

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && fin) |=> (r_seen == 2'd0))
        else $error("vertex count not cleared after final vertex");

    a_j2_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_j2_v |-> (r_seen == 2'd0))
        else $error("pending end job with vertices held");

    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (ab_or[NORM_BITS-1] && !norm_hi))
        else $error("multiply entered with unnormalized operands");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVLD) |-> (r_root != '0))
        else $error("zero root before divide");

endmodule

>>> test/polyline_twin_rail_offset_test.sv
`timescale 1ns / 1ps
// Self-checking bench for polyline_twin_rail_offset: queue-fed driver, rail point
// predictor and scoreboard monitor with random bursts, stalls and gauge changes.
// Depends on ptro_pkg and the polyline_twin_rail_offset RTL.
module polyline_twin_rail_offset_test
    import ptro_pkg::*;
();

    localparam int  CB        = 32;
    localparam int  CYCLE_CAP = 1000000;
    localparam int  SETTLE    = 200;
    localparam logic [CB-1:0] CMAX = 32'h7fffffff;
    localparam logic [CB-1:0] CMIN = 32'h80000000;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          fin;
    } t_vertex;

    typedef struct {
        logic [CB-1:0] lx;
        logic [CB-1:0] ly;
        logic [CB-1:0] rx;
        logic [CB-1:0] ry;
        logic          eol;
    } t_rail;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [GAUGE_BITS-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [CB-1:0]         i_x_coord = '0;
    logic [CB-1:0]         i_y_coord = '0;
    logic                  i_final_vertex = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CB-1:0]         o_left_x, o_left_y, o_right_x, o_right_y;
    logic                  o_end_of_line;

    polyline_twin_rail_offset #(.COORD_BITS(CB)) uut (.*);

    always #1 i_clk = ~i_clk;

    t_vertex         vertex_q[$];
    t_rail           rail_q[$];
    longint unsigned gauge_m = 47022;
    longint          old_x, old_y, new_x, new_y;
    int              held = 0;
    bit              failed = 1'b0;
    bit              beat_taken = 1'b0;
    bit              sender_run = 1'b0;
    bit              long_hold_req = 1'b0;
    int              cycles = 0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [CB-1:0] clamp(longint v);
        if (v > 64'sd2147483647) return CMAX;
        if (v < -64'sd2147483648) return CMIN;
        return v[CB-1:0];
    endfunction

    function automatic t_rail rail_point(longint px, longint py, longint dx, longint dy,
                                         logic eol);
        longint unsigned a, b, m, len, mx, my;
        longint          offx, offy;
        int              bl;
        t_rail           r;
        offx = 0;
        offy = 0;
        a = dx < 0 ? -dx : dx;
        b = dy < 0 ? -dy : dy;
        m = a > b ? a : b;
        if (m != 0) begin
            bl = 0;
            while (bl < 64 && (m >> bl) != 0) bl++;
            if (bl > NORM_BITS) begin
                a >>= (bl - NORM_BITS);
                b >>= (bl - NORM_BITS);
            end else begin
                a <<= (NORM_BITS - bl);
                b <<= (NORM_BITS - bl);
            end
            len = root_floor((a * a + b * b) << 14);
            mx = (2 * gauge_m * (a << 7) + len) / (2 * len);
            my = (2 * gauge_m * (b << 7) + len) / (2 * len);
            offx = dy > 0 ? -longint'(my) : longint'(my);
            offy = dx < 0 ? -longint'(mx) : longint'(mx);
            if (dy == 0) offx = 0;
            if (dx == 0) offy = 0;
        end
        r.lx = clamp(px + offx);
        r.ly = clamp(py + offy);
        r.rx = clamp(px - offx);
        r.ry = clamp(py - offy);
        r.eol = eol;
        return r;
    endfunction

    task automatic predict_vertex(logic [CB-1:0] xi, logic [CB-1:0] yi, logic fin);
        longint px, py;
        px = longint'($signed(xi));
        py = longint'($signed(yi));
        if (held == 0) begin
            if (fin) begin
                rail_q.insert(rail_q.size(), rail_point(px, py, 1, 0, 1'b1));
            end else begin
                new_x = px;
                new_y = py;
                held = 1;
            end
        end else begin
            if (held == 1)
                rail_q.insert(rail_q.size(),
                              rail_point(new_x, new_y, px - new_x, py - new_y, 1'b0));
            else
                rail_q.insert(rail_q.size(),
                              rail_point(new_x, new_y, px - old_x, py - old_y, 1'b0));
            if (fin) begin
                rail_q.insert(rail_q.size(),
                              rail_point(px, py, px - new_x, py - new_y, 1'b1));
                held = 0;
            end else begin
                old_x = new_x;
                old_y = new_y;
                new_x = px;
                new_y = py;
                held = 2;
            end
        end
    endtask

    // input side: predict on each accepted beat
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && i_valid && o_ready) begin
            predict_vertex(i_x_coord, i_y_coord, i_final_vertex);
            beat_taken = 1'b1;
        end
    end

    // output side: compare each beat against the oldest expectation
    always @(posedge i_clk) begin
        t_rail e;
        if (i_rst_n && o_valid && i_ready) begin
            if (rail_q.size() == 0) begin
                $error("unexpected result beat");
                failed = 1'b1;
            end else begin
                e = rail_q.pop_front();
                if (o_left_x !== e.lx) begin
                    $error("left_x exp %h got %h", e.lx, o_left_x); failed = 1'b1;
                end
                if (o_left_y !== e.ly) begin
                    $error("left_y exp %h got %h", e.ly, o_left_y); failed = 1'b1;
                end
                if (o_right_x !== e.rx) begin
                    $error("right_x exp %h got %h", e.rx, o_right_x); failed = 1'b1;
                end
                if (o_right_y !== e.ry) begin
                    $error("right_y exp %h got %h", e.ry, o_right_y); failed = 1'b1;
                end
                if (o_end_of_line !== e.eol) begin
                    $error("end_of_line exp %b got %b", e.eol, o_end_of_line);
                    failed = 1'b1;
                end
            end
        end
    end

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        logic    nv;
        t_vertex v;
        nv = i_valid;
        if (nv && beat_taken) nv = 1'b0;
        beat_taken = 1'b0;
        if (!nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (sender_run && vertex_q.size() != 0) begin
                v = vertex_q.pop_front();
                i_x_coord <= v.x;
                i_y_coord <= v.y;
                i_final_vertex <= v.fin;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        i_valid <= nv;
    end

    // receiver: random stall pattern that changes over time, plus a long hold
    int hold_left = 0;
    int stall_pct = 0;
    always @(negedge i_clk) begin
        logic rdy;
        if (cycles % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            rdy = $urandom_range(0, 99) >= stall_pct;
        end
        i_ready <= rdy;
    end

    function automatic void add_vertex(logic [CB-1:0] x, logic [CB-1:0] y, logic fin);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.fin = fin;
        vertex_q.insert(vertex_q.size(), v);
    endfunction

    function automatic logic [CB-1:0] step_coord(logic [CB-1:0] c);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? CMAX : CMIN;
            2: return c;
            3, 4: return c + $urandom_range(0, 15) - 8;
            default: return c + {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    function automatic void add_polyline();
        int            n;
        logic [CB-1:0] x, y;
        n = $urandom_range(0, 5) == 0 ? 1 : $urandom_range(2, 9);
        x = $urandom;
        y = $urandom;
        for (int k = 0; k < n; k++) begin
            x = step_coord(x);
            y = step_coord(y);
            add_vertex(x, y, k == n - 1);
        end
    endfunction

    task automatic run_and_drain();
        sender_run = 1'b1;
        while (vertex_q.size() != 0 || i_valid || rail_q.size() != 0)
            @(posedge i_clk);
        sender_run = 1'b0;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_gauge(logic [GAUGE_BITS-1:0] g);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= g;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gauge_m = g;
    endtask

    function automatic void add_random(int count);
        int start;
        start = vertex_q.size();
        while (vertex_q.size() - start < count) add_polyline();
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset gauge
        add_vertex(0, 0, 1'b1);
        add_vertex(CMAX, CMAX, 1'b1);
        add_vertex(CMIN, CMIN, 1'b1);
        add_vertex(0, 0, 1'b0);
        add_vertex(32'h10000, 0, 1'b1);
        add_vertex(5, 5, 1'b0);
        add_vertex(5, 5, 1'b0);
        add_vertex(5, 5, 1'b1);
        add_vertex(CMAX, CMIN, 1'b0);
        add_vertex(CMIN, CMAX, 1'b0);
        add_vertex(CMAX, CMAX, 1'b1);
        add_vertex(0, 0, 1'b0);
        add_vertex(0, 100, 1'b0);
        add_vertex(0, -300, 1'b1);
        run_and_drain();

        set_gauge(GAUGE_BITS'(262143));
        add_vertex(CMAX - 5, CMAX - 5, 1'b0);
        add_vertex(CMAX, CMAX - 9, 1'b0);
        add_vertex(CMIN, CMIN + 3, 1'b1);
        add_vertex(CMIN, 7, 1'b1);
        add_random(200);
        run_and_drain();

        set_gauge('0);
        add_vertex(1, 2, 1'b0);
        add_vertex(3, -4, 1'b1);
        add_random(200);
        run_and_drain();

        set_gauge(GAUGE_BITS'($urandom));
        add_random(220);
        long_hold_req = 1'b1;
        run_and_drain();

        set_gauge(HALF_GAUGE_RST);
        add_random(200);
        run_and_drain();

        set_gauge(GAUGE_BITS'($urandom));
        add_random(200);
        run_and_drain();

        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
